@@ hw/rtl/lseg_pkg.sv @@
// ----------------------------------------------------------------------------
// LED strip effect generator package
// Shared codes, limits, handshake structs and the colour wheel.
// ----------------------------------------------------------------------------
package lseg_pkg;

  // Result and strip limits
  localparam int unsigned MAX_RESULTS       = 32;
  localparam int unsigned NUM_PIXELS_DEFAULT = 32;
  localparam int unsigned PIXEL_IDX_W       = 5;
  localparam int unsigned COUNT_W           = 6;
  localparam int unsigned FRAME_W           = 11;

  // Register indexes
  localparam logic [1:0] REG_EFFECT_MODE = 2'd0;
  localparam logic [1:0] REG_SOLID_COLOR = 2'd1;
  localparam logic [1:0] REG_PIXEL_COUNT = 2'd2;

  // Effect codes
  localparam logic [2:0] MODE_WIPE          = 3'd0;
  localparam logic [2:0] MODE_RAINBOW       = 3'd1;
  localparam logic [2:0] MODE_CYCLE         = 3'd2;
  localparam logic [2:0] MODE_CHASE         = 3'd3;
  localparam logic [2:0] MODE_CHASE_RAINBOW = 3'd4;

  // Register reset values
  localparam logic [2:0]  EFFECT_MODE_RESET = MODE_CYCLE;
  localparam logic [23:0] SOLID_COLOR_RESET = 24'd0;
  localparam logic [5:0]  PIXEL_COUNT_RESET = 6'd21;

  // Effect lengths
  localparam logic [10:0] RAINBOW_LEN        = 11'd256;
  localparam logic [10:0] CYCLE_LEN          = 11'd1280;
  localparam logic [10:0] CHASE_OUTER        = 11'd10;
  localparam logic [10:0] CHASE_RAINBOW_OUTER = 11'd256;
  localparam logic [1:0]  CHASE_LAST_PHASE   = 2'd2;   // phases 0..2, stride of three

  // Colour wheel breakpoints
  localparam logic [7:0]  WHEEL_SEG1 = 8'd85;
  localparam logic [7:0]  WHEEL_SEG2 = 8'd170;
  localparam logic [7:0]  LEVEL_MAX  = 8'd255;
  localparam logic [11:0] WHEEL_WRAP = 12'd255;

  // Divider: 256 / n, one quotient bit per cycle
  localparam int unsigned DIV_STEPS = 9;
  localparam int unsigned DIV_CNT_W = 4;

  typedef struct packed {
    logic start;    // latch frame, update effect state, clear divider
    logic divide;   // one restoring division step
    logic emit;     // load output register with current pixel, advance
  } lseg_cmd_t;

  typedef struct packed {
    logic div_done;
    logic last_pixel;
  } lseg_status_t;

  function automatic logic [7:0] times3(input logic [7:0] v);
    logic [9:0] w;
    w = {2'b00, v} + {1'b0, v, 1'b0};
    return w[7:0];
  endfunction

  // Red to green to blue and back to red
  function automatic logic [23:0] wheel(input logic [7:0] pos);
    logic [7:0] p;
    logic [7:0] t;
    p = LEVEL_MAX - pos;
    if (p < WHEEL_SEG1) begin
      t = times3(p);
      return {LEVEL_MAX - t, 8'd0, t};
    end else if (p < WHEEL_SEG2) begin
      t = times3(p - WHEEL_SEG1);
      return {8'd0, t, LEVEL_MAX - t};
    end else begin
      t = times3(p - WHEEL_SEG2);
      return {t, LEVEL_MAX - t, 8'd0};
    end
  endfunction

endpackage

@@ hw/rtl/lseg_ctrl.sv @@
// ----------------------------------------------------------------------------
// LED strip effect generator controller
// Sequences accept, divide and per-pixel emit; owns the output valid.
// ----------------------------------------------------------------------------
module lseg_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output lseg_pkg::lseg_cmd_t   cmd,
  input  lseg_pkg::lseg_status_t status
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

  state_t state;

  always_comb begin
    s_tready   = (state == ST_IDLE);
    cmd.start  = (state == ST_IDLE) && s_tvalid;
    cmd.divide = (state == ST_DIVIDE) && !status.div_done;
    cmd.emit   = (state == ST_EMIT) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) state <= ST_DIVIDE;
        end
        ST_DIVIDE: begin
          if (status.div_done) state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (cmd.emit && status.last_pixel) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
      // hold the result until taken
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

@@ hw/rtl/lseg_datapath.sv @@
// ----------------------------------------------------------------------------
// LED strip effect generator datapath
// Registers, effect state, 256/n divider, pixel colour and output register.
// ----------------------------------------------------------------------------
module lseg_datapath #(
  parameter int unsigned PIXEL_CAP = lseg_pkg::MAX_RESULTS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [23:0]                 cfg_data,
  input  logic                        abort_request,
  input  lseg_pkg::lseg_cmd_t         cmd,
  output lseg_pkg::lseg_status_t      status,
  output logic [lseg_pkg::PIXEL_IDX_W-1:0] pixel_index,
  output logic [7:0]                  red,
  output logic [7:0]                  green,
  output logic [7:0]                  blue,
  output logic                        last_in_frame,
  output logic                        cycle_done
);

  localparam logic [5:0] CAP = 6'(PIXEL_CAP);

  // configuration
  logic [2:0]  effect_mode;
  logic [23:0] solid_color;
  logic [5:0]  pixel_count;

  // effect state
  logic [10:0] frame_counter;
  logic [1:0]  chase_phase;
  logic        wipe_filled;
  logic [10:0] frame_counter_next;
  logic [1:0]  chase_phase_next;
  logic        wipe_filled_next;
  logic        done_next;

  // frame snapshot
  logic [10:0] frame_j;
  logic [1:0]  phase_q;
  logic        filled_snap;
  logic        done_snap;

  // divider and pixel walk
  logic [lseg_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [5:0]  div_rem;
  logic [7:0]  div_quo;
  logic [6:0]  div_shift;
  logic [4:0]  pix;
  logic [1:0]  pix_mod3;
  logic [7:0]  acc_q;
  logic [5:0]  acc_r;
  logic [6:0]  acc_r_sum;

  logic [5:0]  n_active;
  logic [10:0] j_inc;
  logic [23:0] color;
  logic [4:0]  chase_diff;
  logic [11:0] chase_sum;
  logic [11:0] chase_pos;
  logic        chase_lit;

  always_comb begin
    if (pixel_count == 6'd0) begin
      n_active = 6'd1;
    end else if (pixel_count > CAP) begin
      n_active = CAP;
    end else begin
      n_active = pixel_count;
    end
  end

  // effect state for the frame being accepted
  always_comb begin
    j_inc              = frame_counter + 11'd1;
    frame_counter_next = frame_counter;
    chase_phase_next   = chase_phase;
    wipe_filled_next   = wipe_filled;
    done_next          = 1'b0;
    unique case (effect_mode)
      lseg_pkg::MODE_WIPE: begin
        if (j_inc >= {5'd0, n_active}) begin
          done_next        = 1'b1;
          wipe_filled_next = 1'b1;
        end else begin
          frame_counter_next = j_inc;
        end
      end
      lseg_pkg::MODE_RAINBOW: begin
        if (abort_request || j_inc >= lseg_pkg::RAINBOW_LEN) done_next = 1'b1;
        else frame_counter_next = j_inc;
      end
      lseg_pkg::MODE_CYCLE: begin
        if (abort_request || j_inc >= lseg_pkg::CYCLE_LEN) done_next = 1'b1;
        else frame_counter_next = j_inc;
      end
      lseg_pkg::MODE_CHASE: begin
        if (abort_request || (chase_phase >= lseg_pkg::CHASE_LAST_PHASE &&
                              j_inc >= lseg_pkg::CHASE_OUTER)) begin
          done_next = 1'b1;
        end else if (chase_phase >= lseg_pkg::CHASE_LAST_PHASE) begin
          chase_phase_next   = 2'd0;
          frame_counter_next = j_inc;
        end else begin
          chase_phase_next = chase_phase + 2'd1;
        end
      end
      lseg_pkg::MODE_CHASE_RAINBOW: begin
        if (abort_request || (chase_phase >= lseg_pkg::CHASE_LAST_PHASE &&
                              j_inc >= lseg_pkg::CHASE_RAINBOW_OUTER)) begin
          done_next = 1'b1;
        end else if (chase_phase >= lseg_pkg::CHASE_LAST_PHASE) begin
          chase_phase_next   = 2'd0;
          frame_counter_next = j_inc;
        end else begin
          chase_phase_next = chase_phase + 2'd1;
        end
      end
      default: done_next = 1'b0;
    endcase
    if (done_next) begin
      frame_counter_next = 11'd0;
      chase_phase_next   = 2'd0;
    end
  end

  // restoring division step and remainder walk
  always_comb begin
    div_shift = {div_rem, (div_cnt == '0)};
    acc_r_sum = {1'b0, acc_r} + {1'b0, div_rem};
  end

  // colour of the current pixel
  always_comb begin
    chase_lit  = (pix_mod3 == phase_q);
    chase_diff = pix - {3'd0, phase_q};
    chase_sum  = {7'd0, chase_diff} + {1'b0, frame_j};
    chase_pos  = (chase_sum >= lseg_pkg::WHEEL_WRAP) ? chase_sum - lseg_pkg::WHEEL_WRAP
                                                     : chase_sum;
    case (effect_mode)
      lseg_pkg::MODE_WIPE:
        color = (({6'd0, pix} <= frame_j) || filled_snap) ? solid_color : 24'd0;
      lseg_pkg::MODE_RAINBOW:
        color = lseg_pkg::wheel({3'd0, pix} + frame_j[7:0]);
      lseg_pkg::MODE_CYCLE:
        color = lseg_pkg::wheel(acc_q + frame_j[7:0]);
      lseg_pkg::MODE_CHASE:
        color = chase_lit ? solid_color : 24'd0;
      lseg_pkg::MODE_CHASE_RAINBOW:
        color = chase_lit ? lseg_pkg::wheel(chase_pos[7:0]) : 24'd0;
      default:
        color = 24'd0;
    endcase
  end

  always_comb begin
    status.div_done   = (div_cnt == lseg_pkg::DIV_CNT_W'(lseg_pkg::DIV_STEPS));
    status.last_pixel = ({1'b0, pix} + 6'd1 == n_active);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      effect_mode   <= lseg_pkg::EFFECT_MODE_RESET;
      solid_color   <= lseg_pkg::SOLID_COLOR_RESET;
      pixel_count   <= lseg_pkg::PIXEL_COUNT_RESET;
      frame_counter <= 11'd0;
      chase_phase   <= 2'd0;
      wipe_filled   <= 1'b0;
      div_cnt       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          lseg_pkg::REG_EFFECT_MODE: begin
            effect_mode   <= cfg_data[2:0];
            frame_counter <= 11'd0;
            chase_phase   <= 2'd0;
            wipe_filled   <= 1'b0;
          end
          lseg_pkg::REG_SOLID_COLOR: solid_color <= cfg_data;
          lseg_pkg::REG_PIXEL_COUNT: pixel_count <= cfg_data[5:0];
          default: ;
        endcase
      end else if (cmd.start) begin
        frame_counter <= frame_counter_next;
        chase_phase   <= chase_phase_next;
        wipe_filled   <= wipe_filled_next;
      end
      if (cmd.start) begin
        div_cnt <= '0;
      end else if (cmd.divide) begin
        div_cnt <= div_cnt + lseg_pkg::DIV_CNT_W'(1);
      end
    end
  end

  // payload: snapshot, divider, walk and output register
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      frame_j     <= frame_counter;
      phase_q     <= chase_phase;
      filled_snap <= wipe_filled;
      done_snap   <= done_next;
      div_rem     <= 6'd0;
      div_quo     <= 8'd0;
      pix         <= 5'd0;
      pix_mod3    <= 2'd0;
      acc_q       <= 8'd0;
      acc_r       <= 6'd0;
    end else if (cmd.divide) begin
      // the top quotient bit only matters for a single pixel, where it is unused
      if (div_shift >= {1'b0, n_active}) begin
        div_rem <= 6'(div_shift - {1'b0, n_active});
        div_quo <= {div_quo[6:0], 1'b1};
      end else begin
        div_rem <= div_shift[5:0];
        div_quo <= {div_quo[6:0], 1'b0};
      end
    end else if (cmd.emit) begin
      pixel_index   <= pix;
      red           <= color[23:16];
      green         <= color[15:8];
      blue          <= color[7:0];
      last_in_frame <= status.last_pixel;
      cycle_done    <= done_snap;
      pix           <= pix + 5'd1;
      pix_mod3      <= (pix_mod3 == lseg_pkg::CHASE_LAST_PHASE) ? 2'd0 : pix_mod3 + 2'd1;
      // next floor(i*256/n): add quotient, carry remainder overflow
      if (acc_r_sum >= {1'b0, n_active}) begin
        acc_r <= 6'(acc_r_sum - {1'b0, n_active});
        acc_q <= acc_q + div_quo + 8'd1;
      end else begin
        acc_r <= acc_r_sum[5:0];
        acc_q <= acc_q + div_quo;
      end
    end
  end

endmodule

@@ hw/rtl/led_strip_effect_generator_top.sv @@
// ----------------------------------------------------------------------------
// LED strip effect generator, top level
// One frame tick in, one RGB result per pixel in use out.
//
//   channel   | direction | payload
//   ----------+-----------+---------------------------------------------------
//   s_axis    | in        | tdata[0] abort_request
//   m_axis    | out       | tdata pixel_index, red, green, blue; tlast; tuser
//   cfg       | in        | cfg_index selects mode, solid colour, pixel count
//
// The tick is taken, then the divide state runs nine steps of the
// 256/n quotient used by the spread rainbow and hands over, then one
// pixel is emitted per cycle while the sink keeps up, through the single
// output register; the divider is bit-serial.
// Reset (rst, synchronous) restores the register defaults and the first frame.
// A stalled sink holds the output register; the walk waits, nothing is lost.
// ----------------------------------------------------------------------------
module led_strip_effect_generator_top #(
  parameter int unsigned NUM_PIXELS = lseg_pkg::NUM_PIXELS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // frame tick stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] abort_request, [7:1] zero
  // pixel stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [4:0] pixel_index, [12:5] red, [20:13] green,
                                 // [28:21] blue, [31:29] zero
  output logic        m_tlast,   // last_in_frame
  output logic [0:0]  m_tuser,   // [0] cycle_done
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  // strip in use never exceeds the result limit
  localparam int unsigned PIXEL_CAP =
    (NUM_PIXELS < lseg_pkg::MAX_RESULTS) ? NUM_PIXELS : lseg_pkg::MAX_RESULTS;

  lseg_pkg::lseg_cmd_t    cmd;
  lseg_pkg::lseg_status_t status;

  logic [lseg_pkg::PIXEL_IDX_W-1:0] pixel_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       last_in_frame;
  logic       cycle_done;

  // sequence the frame: accept, divide, emit each pixel
  lseg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  // hold registers and effect state, colour each pixel
  lseg_datapath #(
    .PIXEL_CAP (PIXEL_CAP)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .abort_request (s_tdata[0]),
    .cmd           (cmd),
    .status        (status),
    .pixel_index   (pixel_index),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .last_in_frame (last_in_frame),
    .cycle_done    (cycle_done)
  );

  // pack the result transaction
  assign m_tdata    = {3'd0, blue, green, red, pixel_index};
  assign m_tlast    = last_in_frame;
  assign m_tuser[0] = cycle_done;

`ifndef SYNTHESIS
  // a frame tick blocks further ticks until its pixels are walked
  a_tick_blocks: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("frame tick accepted while a frame is in flight");

  // no pixel is emitted outside a frame
  a_no_idle_emit: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !cmd.emit)
    else $error("pixel emitted while idle");

  // the last pixel of the walk carries tlast
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && status.last_pixel) |=> (m_tvalid && m_tlast))
    else $error("last pixel emitted without tlast");
`endif

endmodule
